@@ hdl/psu_pkg.sv @@
// Package for the particle swarm update unit: widths, opcodes, defaults, queue entry type.
// No dependencies.
package psu_pkg;
  localparam int PARTICLES_DEF = 32;
  localparam int DIMS_DEF = 16;
  localparam int PW = 5;
  localparam int DW = 4;
  localparam int FW = 63;
  localparam logic [FW-1:0] MAX63 = {FW{1'b1}};

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_W = 3'd0,
    REG_C1 = 3'd1,
    REG_C2 = 3'd2,
    REG_FLOOR = 3'd3,
    REG_CEIL = 3'd4
  } reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_K, S_M1, S_M2, S_M3, S_SUM, S_POS, S_SQ, S_ACC, S_BEST, S_COPY,
    S_OUT
  } st_t;

  typedef struct packed {
    op_t op;
    logic valid;
    logic [PW-1:0] p;
    logic [DW-1:0] d;
    logic [31:0] ipos;
    logic [31:0] ivel;
    logic [15:0] r1;
    logic [15:0] r2;
    logic last;
  } cmd_t;
endpackage

@@ hdl/psu_front.sv @@
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on psu_pkg.
module psu_front #(
  parameter int PARTICLES = psu_pkg::PARTICLES_DEF,
  parameter int DIMS = psu_pkg::DIMS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic [1:0] in_opcode,
  input  logic [psu_pkg::PW-1:0] in_particle_index,
  input  logic [psu_pkg::DW-1:0] in_dimension_index,
  input  logic [31:0] in_init_position,
  input  logic [31:0] in_init_velocity,
  input  logic [15:0] in_rand_cognitive,
  input  logic [15:0] in_rand_social,
  input  logic in_last_dimension,
  output logic q_nempty,
  output psu_pkg::cmd_t q_head,
  input  logic q_pop
);
  import psu_pkg::*;
  cmd_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t c;
  logic push;

  always_comb begin
    c.op = op_t'(in_opcode);
    c.p = in_particle_index;
    c.d = in_dimension_index;
    c.ipos = in_init_position;
    c.ivel = in_init_velocity;
    c.r1 = in_rand_cognitive;
    c.r2 = in_rand_social;
    c.last = in_last_dimension;
    c.valid = (32'(in_particle_index) < 32'(PARTICLES)) && (32'(in_dimension_index) < 32'(DIMS));
  end

  assign in_full = cnt_r[1];
  assign push = in_push && !in_full;
  assign q_nempty = cnt_r != 2'd0;
  assign q_head = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_nempty)
    else $error("pop on empty queue");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_full && !q_pop) |=> in_full) else $error("full dropped without pop");
endmodule

@@ hdl/psu_back.sv @@
// Back end: sequencer with element memories, shared multiplier, best-vector commit.
// Depends on psu_pkg.
module psu_back #(
  parameter int PARTICLES = psu_pkg::PARTICLES_DEF,
  parameter int DIMS = psu_pkg::DIMS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_write_enable,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic q_nempty,
  input  psu_pkg::cmd_t q_head,
  output logic q_pop,
  output logic out_empty,
  input  logic out_pop,
  output logic [31:0] out_new_position,
  output logic [31:0] out_new_velocity,
  output logic [psu_pkg::FW-1:0] out_particle_fitness,
  output logic out_particle_done,
  output logic out_personal_improved,
  output logic out_global_improved,
  output logic [psu_pkg::FW-1:0] out_best_fitness
);
  import psu_pkg::*;
  localparam int PB = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int DB = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int EB = PB + DB;
  localparam int NE = PARTICLES * (1 << DB);

  logic [15:0] w_r, c1_r, c2_r;
  logic signed [31:0] lo_r, hi_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 16'd2048;
      c1_r <= 16'd6144;
      c2_r <= 16'd6144;
      lo_r <= -32'sd655360;
      hi_r <= 32'sd655360;
    end else if (cfg_write_enable) begin
      unique case (reg_t'(cfg_index))
        REG_W: w_r <= cfg_data[15:0];
        REG_C1: c1_r <= cfg_data[15:0];
        REG_C2: c2_r <= cfg_data[15:0];
        REG_FLOOR: lo_r <= cfg_data;
        REG_CEIL: hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [31:0] pos_mem [NE];
  logic [31:0] vel_mem [NE];
  logic [31:0] pb_mem [NE];
  logic [FW-1:0] pbf_mem [PARTICLES];
  logic [31:0] gb_r [DIMS];
  logic [FW-1:0] gbf_r, acc_r;

  st_t st_r, st_nxt;
  cmd_t cmd_r;
  logic [EB-1:0] e_r, base_e;
  logic [DB-1:0] d_q;
  logic [PB-1:0] p_q;
  logic signed [31:0] x_r, v_r, pbv_r, gbv_r, nv_r;
  logic [15:0] k1_r, k2_r;
  logic signed [63:0] sum_r;
  logic [FW-1:0] pbf_rd_r, sq_r, fit_r;
  logic pimp_r, gimp_r;
  logic [DB:0] cp_r;
  logic [DB-1:0] cpd;
  logic [31:0] cp_data_r;
  logic cp_wr_r;
  logic [DB-1:0] cp_wd_r;

  // result register
  logic ovalid_r;
  assign out_empty = !ovalid_r;

  assign d_q = q_head.d[DB-1:0];
  assign p_q = q_head.p[PB-1:0];
  assign base_e = {cmd_r.p[PB-1:0], {DB{1'b0}}};
  assign cpd = cp_r[DB-1:0];

  // shared multiplier operands
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (st_r)
      S_K: begin ma = {18'd0, c1_r}; mb = {18'd0, cmd_r.r1}; end
      S_M1: begin ma = {18'd0, w_r}; mb = {{2{v_r[31]}}, v_r}; end
      S_M2: begin ma = {18'd0, k1_r}; mb = 34'(pbv_r) - 34'(x_r); end
      S_M3: begin ma = {18'd0, k2_r}; mb = 34'(gbv_r) - 34'(x_r); end
      S_SQ: begin ma = {{2{x_r[31]}}, x_r}; mb = {{2{x_r[31]}}, x_r}; end
      default: ;
    endcase
  end
  assign mp = ma * mb;

  logic signed [63:0] fl;
  logic signed [32:0] xs;
  logic signed [31:0] xn;
  logic [FW:0] accs;
  logic [FW-1:0] accsat;
  always_comb begin
    fl = sum_r >>> 12;
    xs = 33'(x_r) + 33'(nv_r);
    if (xs < 33'(lo_r)) xn = lo_r;
    else if (xs > 33'(hi_r)) xn = hi_r;
    else xn = xs[31:0];
    if (xn > hi_r) xn = hi_r;
    accs = {1'b0, acc_r} + {1'b0, sq_r};
    accsat = accs[FW] ? MAX63 : accs[FW-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_nempty && !ovalid_r) st_nxt = S_RD;
      S_RD: begin
        if (cmd_r.op == OP_UPDATE && cmd_r.valid) st_nxt = S_K;
        else if (cmd_r.op == OP_INIT && cmd_r.valid) st_nxt = S_SQ;
        else st_nxt = S_OUT;
      end
      S_K: st_nxt = S_M1;
      S_M1: st_nxt = S_M2;
      S_M2: st_nxt = S_M3;
      S_M3: st_nxt = S_SUM;
      S_SUM: st_nxt = S_POS;
      S_POS: st_nxt = S_SQ;
      S_SQ: st_nxt = S_ACC;
      S_ACC: st_nxt = cmd_r.last ? S_BEST : S_OUT;
      S_BEST: st_nxt = (pimp_r || fit_r < gbf_r) ? S_COPY : S_OUT;
      S_COPY: if (cp_r == (DB+1)'(DIMS)) st_nxt = S_OUT;
      S_OUT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (st_r == S_IDLE) && q_nempty && !ovalid_r;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: if (q_pop) begin
        cmd_r <= q_head;
        e_r <= {p_q, d_q};
        x_r <= pos_mem[{p_q, d_q}];
        v_r <= vel_mem[{p_q, d_q}];
        pbv_r <= pb_mem[{p_q, d_q}];
        gbv_r <= gb_r[d_q];
        pbf_rd_r <= pbf_mem[p_q];
      end
      S_RD: if (cmd_r.op == OP_INIT && cmd_r.valid) begin
        x_r <= cmd_r.ipos;
        nv_r <= cmd_r.ivel;
        pos_mem[e_r] <= cmd_r.ipos;
        vel_mem[e_r] <= cmd_r.ivel;
        pb_mem[e_r] <= cmd_r.ipos;
      end
      S_K: k1_r <= mp[31:16];
      S_M1: begin k2_r <= 16'(((32'(c2_r) * 32'(cmd_r.r2)) >> 16)); sum_r <= 64'(mp); end
      S_M2: sum_r <= sum_r + 64'(mp);
      S_M3: sum_r <= sum_r + 64'(mp);
      S_SUM: begin
        if (fl > 64'sh7FFFFFFF) nv_r <= 32'sh7FFFFFFF;
        else if (fl < -64'sh80000000) nv_r <= 32'sh80000000;
        else nv_r <= fl[31:0];
      end
      S_POS: begin
        x_r <= xn;
        pos_mem[e_r] <= xn;
        vel_mem[e_r] <= nv_r;
      end
      S_SQ: sq_r <= mp[FW-1:0];
      S_ACC: begin
        fit_r <= accsat;
        pimp_r <= cmd_r.last && (cmd_r.op == OP_INIT || accsat < pbf_rd_r);
        cp_r <= '0;
      end
      S_BEST: begin
        gimp_r <= fit_r < gbf_r;
        if (pimp_r) pbf_mem[cmd_r.p[PB-1:0]] <= fit_r;
      end
      S_COPY: begin
        // read one element per cycle, write it back the cycle after
        if (cp_r != (DB+1)'(DIMS)) begin
          cp_data_r <= pos_mem[base_e | EB'(cpd)];
          cp_r <= cp_r + 1'b1;
        end
      end
      default: ;
    endcase
    cp_wr_r <= (st_r == S_COPY) && (cp_r != (DB+1)'(DIMS));
    cp_wd_r <= cpd;
    if (cp_wr_r && pimp_r) pb_mem[base_e | EB'(cp_wd_r)] <= cp_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ovalid_r <= 1'b0;
      gbf_r <= MAX63;
      acc_r <= '0;
      for (int i = 0; i < DIMS; i++) gb_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_ACC) acc_r <= cmd_r.last ? '0 : accsat;
      if (st_r == S_BEST && fit_r < gbf_r) gbf_r <= fit_r;
      if (cp_wr_r && gimp_r) gb_r[cp_wd_r] <= cp_data_r;
      if (out_pop && ovalid_r) ovalid_r <= 1'b0;
      if (st_r == S_OUT) begin
        ovalid_r <= 1'b1;
        out_best_fitness <= gbf_r;
        if (cmd_r.op == OP_READ) begin
          out_new_position <= (32'(cmd_r.d) < 32'(DIMS)) ? gb_r[cmd_r.d[DB-1:0]] : '0;
          out_new_velocity <= '0;
          out_particle_fitness <= '0;
          out_particle_done <= 1'b0;
          out_personal_improved <= 1'b0;
          out_global_improved <= 1'b0;
        end else if (cmd_r.valid && cmd_r.op != OP_NONE) begin
          out_new_position <= x_r;
          out_new_velocity <= nv_r;
          out_particle_fitness <= cmd_r.last ? fit_r : '0;
          out_particle_done <= cmd_r.last;
          out_personal_improved <= cmd_r.last && pimp_r;
          out_global_improved <= cmd_r.last && gimp_r;
        end else begin
          out_new_position <= '0;
          out_new_velocity <= '0;
          out_particle_fitness <= '0;
          out_particle_done <= 1'b0;
          out_personal_improved <= 1'b0;
          out_global_improved <= 1'b0;
        end
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) |-> !ovalid_r) else $error("result overwritten");
  a_gbf_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 gbf_r <= $past(gbf_r)) else $error("global best grew");
  a_done_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && out_global_improved) |-> out_particle_done) else $error("flag without done");
endmodule

@@ hdl/particle_swarm_update_unit.sv @@
// Top level of the particle swarm update unit: front queue plus back sequencer.
// Depends on psu_pkg, psu_front, psu_back.
//
//  channel  ports                               handshake
//  in       in_opcode .. in_last_dimension      in_push / in_full
//  out      out_new_position .. out_best_fitness out_pop / out_empty
//  cfg      cfg_write_enable, cfg_index, cfg_data  write, no wait
//
// After pop, an update steps RD, K, M1, M2, M3, SUM, POS, SQ, ACC, OUT; an init RD, SQ,
// ACC, OUT; a read or rejected item RD, OUT. The update runs five products in series on
// one shared multiplier. A particle's last element adds the BEST compare, and the COPY
// pass when a best vector is copied. Reset is synchronous; no clearing pass. A two-entry
// queue parts front and back, and the back waits while a result sits unread.
module particle_swarm_update_unit #(
  parameter int PARTICLES = psu_pkg::PARTICLES_DEF,
  parameter int DIMS = psu_pkg::DIMS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_write_enable,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_push,
  output logic in_full,
  input  logic [1:0] in_opcode,
  input  logic [psu_pkg::PW-1:0] in_particle_index,
  input  logic [psu_pkg::DW-1:0] in_dimension_index,
  input  logic [31:0] in_init_position,
  input  logic [31:0] in_init_velocity,
  input  logic [15:0] in_rand_cognitive,
  input  logic [15:0] in_rand_social,
  input  logic in_last_dimension,
  output logic out_empty,
  input  logic out_pop,
  output logic [31:0] out_new_position,
  output logic [31:0] out_new_velocity,
  output logic [psu_pkg::FW-1:0] out_particle_fitness,
  output logic out_particle_done,
  output logic out_personal_improved,
  output logic out_global_improved,
  output logic [psu_pkg::FW-1:0] out_best_fitness
);
  import psu_pkg::*;
  logic q_nempty, q_pop;
  cmd_t q_head;

  psu_front #(.PARTICLES(PARTICLES), .DIMS(DIMS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_opcode, .in_particle_index,
    .in_dimension_index, .in_init_position, .in_init_velocity, .in_rand_cognitive,
    .in_rand_social, .in_last_dimension, .q_nempty, .q_head, .q_pop
  );

  psu_back #(.PARTICLES(PARTICLES), .DIMS(DIMS)) u_back (
    .clk, .rst_n, .cfg_write_enable, .cfg_index, .cfg_data, .q_nempty, .q_head, .q_pop,
    .out_empty, .out_pop, .out_new_position, .out_new_velocity, .out_particle_fitness,
    .out_particle_done, .out_personal_improved, .out_global_improved, .out_best_fitness
  );
endmodule
